FILE: hdl/crc_chk_pkg.sv
package crc_chk_pkg;

  localparam int GEN_WIDTH   = 12;
  localparam int COUNT_WIDTH = 32;

  localparam int BYTE_W    = 8;
  localparam int NIB_W     = 4;
  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 2;
  localparam int DWS_W     = 4;
  localparam int PAD_W     = 3;

  // longest codeword: eight data bits plus the largest generator degree
  localparam int CW_W     = BYTE_W + GEN_WIDTH - 1;
  localparam int CW_IDX_W = $clog2(CW_W);
  localparam int BITS_W   = $clog2(CW_W + 1);
  localparam int DEG_W    = (GEN_WIDTH > 2) ? $clog2(GEN_WIDTH) : 1;
  localparam int BCNT_W   = $clog2(BYTE_W);

  localparam logic [BCNT_W-1:0]    BIT_LAST   = BCNT_W'(BYTE_W - 1);
  localparam logic [GEN_WIDTH-1:0] GEN_RESET  = GEN_WIDTH'(11);
  localparam logic [DWS_W-1:0]     DWS_RESET  = DWS_W'(NIB_W);
  localparam logic [DWS_W-1:0]     DWS_WIDE   = DWS_W'(BYTE_W);

  localparam logic [CFG_IDX_W-1:0] REG_GEN_POLY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DW_SIZE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PADDING  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } ctrl_state_t;

  typedef struct packed {
    logic load;    // take the input word
    logic step;    // process one stream bit
    logic finish;  // emit result, close stream on final word
  } dp_cmd_t;

  typedef struct packed {
    logic has_result;
    logic out_free;
  } dp_status_t;

endpackage

FILE: hdl/crc_codeword_checker_unit.sv
// channel | direction | handshake            | payload
// in      | input     | in_valid / in_stall   | in_data_byte, in_final_byte
// out     | output    | out_valid / out_stall | out_char_valid, out_decoded_char,
//         |           |                       | out_counts_valid, out_codeword_total,
//         |           |                       | out_error_total
// cfg     | input     | cfg_wr_en             | cfg_index, cfg_wdata
//
// Each word: its eight bits are pushed one a cycle through the shift register and
// remainder logic, then a finish step hands the result to the output register.
// A word arriving at an idle block is taken at once; none is taken while bits shift.
// A stalled output holds only the finish cycle; the next word is taken when it frees.
// Synchronous active-low reset, no sweep; the data and result payload are not reset.
module crc_codeword_checker_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [crc_chk_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [crc_chk_pkg::CFG_W-1:0]       cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [crc_chk_pkg::BYTE_W-1:0]      in_data_byte,
  input  logic                                in_final_byte,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_char_valid,
  output logic [crc_chk_pkg::BYTE_W-1:0]      out_decoded_char,
  output logic                                out_counts_valid,
  output logic [crc_chk_pkg::COUNT_WIDTH-1:0] out_codeword_total,
  output logic [crc_chk_pkg::COUNT_WIDTH-1:0] out_error_total
);
  import crc_chk_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  crc_chk_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  crc_chk_dpath u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_data_byte       (in_data_byte),
    .in_final_byte      (in_final_byte),
    .cmd                (cmd),
    .status             (status),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_char_valid     (out_char_valid),
    .out_decoded_char   (out_decoded_char),
    .out_counts_valid   (out_counts_valid),
    .out_codeword_total (out_codeword_total),
    .out_error_total    (out_error_total)
  );

endmodule

FILE: hdl/crc_chk_ctrl.sv
module crc_chk_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  crc_chk_pkg::dp_status_t status,
  output crc_chk_pkg::dp_cmd_t    cmd
);
  import crc_chk_pkg::*;

  ctrl_state_t       state_r, state_nxt;
  logic [BCNT_W-1:0] bcnt_r, bcnt_nxt;
  logic              can_finish;

  assign can_finish = !status.has_result || status.out_free;

  always_comb begin
    state_nxt  = state_r;
    bcnt_nxt   = bcnt_r;
    in_stall   = 1'b1;
    cmd        = '0;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          bcnt_nxt  = '0;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd.step = 1'b1;
        bcnt_nxt = bcnt_r + 1'b1;
        if (bcnt_r == BIT_LAST) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (can_finish) begin
          cmd.finish = 1'b1;
          in_stall   = 1'b0;
          if (in_valid) begin
            cmd.load  = 1'b1;
            bcnt_nxt  = '0;
            state_nxt = ST_RUN;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      bcnt_r  <= '0;
    end else begin
      state_r <= state_nxt;
      bcnt_r  <= bcnt_nxt;
    end
  end

endmodule

FILE: hdl/crc_chk_dpath.sv
module crc_chk_dpath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [crc_chk_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [crc_chk_pkg::CFG_W-1:0]       cfg_wdata,
  input  logic [crc_chk_pkg::BYTE_W-1:0]      in_data_byte,
  input  logic                                in_final_byte,
  input  crc_chk_pkg::dp_cmd_t                cmd,
  output crc_chk_pkg::dp_status_t             status,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_char_valid,
  output logic [crc_chk_pkg::BYTE_W-1:0]      out_decoded_char,
  output logic                                out_counts_valid,
  output logic [crc_chk_pkg::COUNT_WIDTH-1:0] out_codeword_total,
  output logic [crc_chk_pkg::COUNT_WIDTH-1:0] out_error_total
);
  import crc_chk_pkg::*;

  // configuration
  logic [GEN_WIDTH-1:0] gen_r, gen_nxt;
  logic [DWS_W-1:0]     dws_r, dws_nxt;
  logic [PAD_W-1:0]     pad_r, pad_nxt;

  // stream state
  logic [BYTE_W-1:0]      byte_r, byte_nxt;
  logic                   fin_r, fin_nxt;
  logic [CW_W-1:0]        shift_r, shift_nxt;
  logic [BITS_W-1:0]      bits_r, bits_nxt;
  logic [PAD_W-1:0]       skip_r, skip_nxt;
  logic [NIB_W-1:0]       acc_r, acc_nxt;
  logic                   pend_r, pend_nxt;
  logic                   cout_r, cout_nxt;
  logic [BYTE_W-1:0]      cval_r, cval_nxt;
  logic [COUNT_WIDTH-1:0] cw_cnt_r, cw_cnt_nxt;
  logic [COUNT_WIDTH-1:0] err_cnt_r, err_cnt_nxt;

  // result register
  logic                   ov_r, ov_nxt;
  logic                   ochar_v_r, ochar_v_nxt;
  logic [BYTE_W-1:0]      ochar_r, ochar_nxt;
  logic                   ocnt_v_r, ocnt_v_nxt;
  logic [COUNT_WIDTH-1:0] otot_r, otot_nxt;
  logic [COUNT_WIDTH-1:0] oerr_r, oerr_nxt;

  // per-bit codeword logic
  logic [DEG_W-1:0]  deg;
  logic              dw8;
  logic [DWS_W-1:0]  dw_len;
  logic [BITS_W-1:0] cw_len;
  logic [CW_W-1:0]   new_shift;
  logic [BITS_W-1:0] new_bits;
  logic              complete;
  logic [CW_W-1:0]   cw_mask;
  logic [CW_W-1:0]   cw;
  logic [CW_W-1:0]   rem;
  logic [CW_W-1:0]   cw_shr;
  logic [BYTE_W-1:0] dword;

  // degree = index of the top set bit, zero for an all-zero generator
  always_comb begin
    deg = '0;
    for (int i = 1; i < GEN_WIDTH; i++) begin
      if (gen_r[i]) begin
        deg = DEG_W'(i);
      end
    end
  end

  assign dw8       = (dws_r == DWS_WIDE);
  assign dw_len    = dw8 ? DWS_W'(BYTE_W) : DWS_W'(NIB_W);
  assign cw_len    = BITS_W'(dw_len) + BITS_W'(deg);
  assign new_shift = {shift_r[CW_W-2:0], byte_r[BYTE_W-1]};
  assign new_bits  = bits_r + 1'b1;
  assign complete  = (new_bits >= cw_len);

  always_comb begin
    for (int i = 0; i < CW_W; i++) begin
      cw_mask[i] = (BITS_W'(i) < cw_len);
    end
  end

  assign cw = new_shift & cw_mask;

  // long division, one data bit per step; at most eight steps
  always_comb begin
    logic [BITS_W-1:0] pos;
    logic [DWS_W-1:0]  sh;
    rem = cw;
    pos = '0;
    sh  = '0;
    for (int k = 0; k < BYTE_W; k++) begin
      if (DWS_W'(k) < dw_len) begin
        pos = cw_len - BITS_W'(k) - 1'b1;
        sh  = dw_len - DWS_W'(k) - 1'b1;
        if (rem[pos[CW_IDX_W-1:0]]) begin
          rem = rem ^ (CW_W'(gen_r) << sh);
        end
      end
    end
  end

  assign cw_shr = cw >> deg;
  assign dword  = dw8 ? cw_shr[BYTE_W-1:0] : {{NIB_W{1'b0}}, cw_shr[NIB_W-1:0]};

  assign status.has_result = cout_r || fin_r;
  assign status.out_free   = !ov_r || !out_stall;

  always_comb begin
    gen_nxt     = gen_r;
    dws_nxt     = dws_r;
    pad_nxt     = pad_r;
    byte_nxt    = byte_r;
    fin_nxt     = fin_r;
    shift_nxt   = shift_r;
    bits_nxt    = bits_r;
    skip_nxt    = skip_r;
    acc_nxt     = acc_r;
    pend_nxt    = pend_r;
    cout_nxt    = cout_r;
    cval_nxt    = cval_r;
    cw_cnt_nxt  = cw_cnt_r;
    err_cnt_nxt = err_cnt_r;
    ov_nxt      = ov_r && out_stall;
    ochar_v_nxt = ochar_v_r;
    ochar_nxt   = ochar_r;
    ocnt_v_nxt  = ocnt_v_r;
    otot_nxt    = otot_r;
    oerr_nxt    = oerr_r;

    if (cfg_wr_en) begin
      case (cfg_index)
        REG_GEN_POLY: gen_nxt = GEN_WIDTH'(cfg_wdata);
        REG_DW_SIZE:  dws_nxt = cfg_wdata[DWS_W-1:0];
        REG_PADDING: begin
          pad_nxt  = cfg_wdata[PAD_W-1:0];
          skip_nxt = cfg_wdata[PAD_W-1:0];
        end
        default: ;
      endcase
    end

    if (cmd.step) begin
      byte_nxt = {byte_r[BYTE_W-2:0], 1'b0};
      if (skip_r != '0) begin
        skip_nxt = skip_r - 1'b1;
      end else if (complete) begin
        if (cw_cnt_r != '1) cw_cnt_nxt = cw_cnt_r + 1'b1;
        if (rem != '0 && err_cnt_r != '1) err_cnt_nxt = err_cnt_r + 1'b1;
        if (dw8) begin
          cout_nxt = 1'b1;
          cval_nxt = dword;
          pend_nxt = 1'b0;
          acc_nxt  = '0;
        end else if (pend_r) begin
          cout_nxt = 1'b1;
          cval_nxt = {acc_r, dword[NIB_W-1:0]};
          pend_nxt = 1'b0;
          acc_nxt  = '0;
        end else begin
          acc_nxt  = dword[NIB_W-1:0];
          pend_nxt = 1'b1;
        end
        shift_nxt = '0;
        bits_nxt  = '0;
      end else begin
        shift_nxt = new_shift;
        bits_nxt  = new_bits;
      end
    end

    if (cmd.finish) begin
      if (cout_r || fin_r) begin
        ov_nxt      = 1'b1;
        ochar_v_nxt = cout_r;
        ochar_nxt   = cout_r ? cval_r : '0;
        ocnt_v_nxt  = fin_r;
        otot_nxt    = fin_r ? cw_cnt_r : '0;
        oerr_nxt    = fin_r ? err_cnt_r : '0;
      end
      if (fin_r) begin
        shift_nxt   = '0;
        bits_nxt    = '0;
        skip_nxt    = pad_r;
        acc_nxt     = '0;
        pend_nxt    = 1'b0;
        cw_cnt_nxt  = '0;
        err_cnt_nxt = '0;
      end
    end

    if (cmd.load) begin
      byte_nxt = in_data_byte;
      fin_nxt  = in_final_byte;
      cout_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gen_r     <= GEN_RESET;
      dws_r     <= DWS_RESET;
      pad_r     <= '0;
      fin_r     <= 1'b0;
      shift_r   <= '0;
      bits_r    <= '0;
      skip_r    <= '0;
      acc_r     <= '0;
      pend_r    <= 1'b0;
      cout_r    <= 1'b0;
      cw_cnt_r  <= '0;
      err_cnt_r <= '0;
      ov_r      <= 1'b0;
    end else begin
      gen_r     <= gen_nxt;
      dws_r     <= dws_nxt;
      pad_r     <= pad_nxt;
      fin_r     <= fin_nxt;
      shift_r   <= shift_nxt;
      bits_r    <= bits_nxt;
      skip_r    <= skip_nxt;
      acc_r     <= acc_nxt;
      pend_r    <= pend_nxt;
      cout_r    <= cout_nxt;
      cw_cnt_r  <= cw_cnt_nxt;
      err_cnt_r <= err_cnt_nxt;
      ov_r      <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r    <= byte_nxt;
    cval_r    <= cval_nxt;
    ochar_v_r <= ochar_v_nxt;
    ochar_r   <= ochar_nxt;
    ocnt_v_r  <= ocnt_v_nxt;
    otot_r    <= otot_nxt;
    oerr_r    <= oerr_nxt;
  end

  assign out_valid          = ov_r;
  assign out_char_valid     = ochar_v_r;
  assign out_decoded_char   = ochar_r;
  assign out_counts_valid   = ocnt_v_r;
  assign out_codeword_total = otot_r;
  assign out_error_total    = oerr_r;

endmodule

FILE: hdl/crc_chk_checker.sv
module crc_chk_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic                                out_char_valid,
  input logic [crc_chk_pkg::BYTE_W-1:0]      out_decoded_char,
  input logic                                out_counts_valid,
  input logic [crc_chk_pkg::COUNT_WIDTH-1:0] out_codeword_total,
  input logic [crc_chk_pkg::COUNT_WIDTH-1:0] out_error_total
);
  import crc_chk_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_decoded_char) && $stable(out_codeword_total))
    else $error("stalled result word changed");

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while previous word still shifting");

  a_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_char_valid || out_counts_valid)
    else $error("empty result word");

  a_counts_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_counts_valid |-> out_codeword_total == '0 && out_error_total == '0)
    else $error("counts shown on a non-final result");

endmodule

bind crc_codeword_checker_unit crc_chk_checker u_chk (.*);

FILE: verif/crc_stream_checker.sv
`timescale 1ns / 100ps
module crc_stream_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [crc_chk_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [crc_chk_pkg::CFG_W-1:0]       cfg_wdata,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic [crc_chk_pkg::BYTE_W-1:0]      in_data_byte,
  input  logic                                in_final_byte,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic                                out_char_valid,
  input  logic [crc_chk_pkg::BYTE_W-1:0]      out_decoded_char,
  input  logic                                out_counts_valid,
  input  logic [crc_chk_pkg::COUNT_WIDTH-1:0] out_codeword_total,
  input  logic [crc_chk_pkg::COUNT_WIDTH-1:0] out_error_total,
  output int                                  fail_count,
  output int                                  pending_count,
  output int                                  results_seen
);
  import crc_chk_pkg::*;

  typedef struct packed {
    logic                   char_valid;
    logic [BYTE_W-1:0]      decoded_char;
    logic                   counts_valid;
    logic [COUNT_WIDTH-1:0] codeword_total;
    logic [COUNT_WIDTH-1:0] error_total;
  } crc_result_t;

  logic [GEN_WIDTH-1:0]   gen_poly;
  logic [DWS_W-1:0]       dw_size;
  logic [PAD_W-1:0]       pad_bits;
  logic [23:0]            shift_bits;
  int unsigned            bit_count;
  logic [PAD_W-1:0]       skip_cnt;
  logic [BYTE_W-1:0]      nib_accum;
  logic                   half_pend;
  logic [COUNT_WIDTH-1:0] cw_count;
  logic [COUNT_WIDTH-1:0] err_count;
  crc_result_t            pending_results[$];
  int                     fails;
  int                     seen;

  function automatic int unsigned poly_length(logic [GEN_WIDTH-1:0] g);
    int unsigned n;
    n = 0;
    for (int i = 0; i < GEN_WIDTH; i++)
      if (g[i]) n = i + 1;
    return n;
  endfunction

  task automatic clear_stream();
    shift_bits = '0;
    bit_count  = 0;
    skip_cnt   = pad_bits;
    nib_accum  = '0;
    half_pend  = 1'b0;
    cw_count   = '0;
    err_count  = '0;
  endtask

  // runs the eight bits of one word through codeword assembly and division
  task automatic decode_word(input logic [BYTE_W-1:0] data, input logic last);
    int unsigned glen, deg, dwl, cwl, cw, rem, dword;
    logic              char_out;
    logic [BYTE_W-1:0] char_val;
    crc_result_t       res;
    glen     = poly_length(gen_poly);
    deg      = (glen != 0) ? glen - 1 : 0;
    dwl      = (dw_size == DWS_WIDE) ? 8 : 4;
    cwl      = dwl + deg;
    char_out = 1'b0;
    char_val = '0;
    for (int b = BYTE_W - 1; b >= 0; b--) begin
      if (skip_cnt != 0) begin
        skip_cnt--;
        continue;
      end
      shift_bits = {shift_bits[22:0], data[b]};
      if (bit_count < 31) bit_count++;
      // a shrunken codeword length can leave more bits than needed: keep the low ones
      if (bit_count >= cwl) begin
        cw  = 32'(shift_bits) & ((32'd1 << cwl) - 1);
        rem = cw;
        if (glen != 0) begin
          for (int i = cwl; i > deg; i--)
            if (((rem >> (i - 1)) & 1) != 0) rem ^= 32'(gen_poly) << (i - 1 - deg);
        end
        if (cw_count != '1) cw_count++;
        if (rem != 0 && err_count != '1) err_count++;
        dword = (cw >> deg) & ((32'd1 << dwl) - 1);
        if (dwl == 8) begin
          char_out  = 1'b1;
          char_val  = 8'(dword);
          half_pend = 1'b0;
          nib_accum = '0;
        end else if (half_pend) begin
          char_out  = 1'b1;
          char_val  = nib_accum | 8'(dword);
          half_pend = 1'b0;
          nib_accum = '0;
        end else begin
          nib_accum = {4'(dword), 4'h0};
          half_pend = 1'b1;
        end
        bit_count  = 0;
        shift_bits = '0;
      end
    end
    if (char_out || last) begin
      res.char_valid     = char_out;
      res.decoded_char   = char_out ? char_val : '0;
      res.counts_valid   = last;
      res.codeword_total = last ? cw_count : '0;
      res.error_total    = last ? err_count : '0;
      pending_results.push_back(res);
    end
    if (last) clear_stream();
  endtask

  task automatic compare_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    crc_result_t want;
    if (!rst_n) begin
      gen_poly = GEN_RESET;
      dw_size  = DWS_RESET;
      pad_bits = '0;
      clear_stream();
      pending_results.delete();
      fails = 0;
      seen  = 0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_GEN_POLY: gen_poly = cfg_wdata[GEN_WIDTH-1:0];
          REG_DW_SIZE:  dw_size  = cfg_wdata[DWS_W-1:0];
          REG_PADDING: begin
            pad_bits = cfg_wdata[PAD_W-1:0];
            skip_cnt = pad_bits;
          end
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        seen++;
        if (pending_results.size() == 0) begin
          $error("unexpected result: char_valid %0d char 0x%0h counts_valid %0d total %0d err %0d",
                 out_char_valid, out_decoded_char, out_counts_valid, out_codeword_total,
                 out_error_total);
          fails++;
        end else begin
          want = pending_results.pop_front();
          compare_field("char_valid", 32'(want.char_valid), 32'(out_char_valid));
          compare_field("decoded_char", 32'(want.decoded_char), 32'(out_decoded_char));
          compare_field("counts_valid", 32'(want.counts_valid), 32'(out_counts_valid));
          compare_field("codeword_total", want.codeword_total, out_codeword_total);
          compare_field("error_total", want.error_total, out_error_total);
        end
      end
      if (in_valid && !in_stall) decode_word(in_data_byte, in_final_byte);
    end
    fail_count    <= fails;
    pending_count <= pending_results.size();
    results_seen  <= seen;
  end

endmodule

FILE: verif/tb_crc_codeword_checker_unit.sv
`timescale 1ns / 100ps
module tb_crc_codeword_checker_unit;
  import crc_chk_pkg::*;

  localparam int QUIET_LIMIT    = 4000;
  localparam int SETTLE_CYCLES  = 12;
  localparam int WORDS_PER_MODE = 333;

  logic                   clk           = 1'b0;
  logic                   rst_n         = 1'b0;
  logic                   cfg_wr_en     = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index     = REG_GEN_POLY;
  logic [CFG_W-1:0]       cfg_wdata     = '0;
  logic                   in_valid      = 1'b0;
  logic                   in_stall;
  logic [BYTE_W-1:0]      in_data_byte  = '0;
  logic                   in_final_byte = 1'b0;
  logic                   out_valid;
  logic                   out_stall     = 1'b0;
  logic                   out_char_valid;
  logic [BYTE_W-1:0]      out_decoded_char;
  logic                   out_counts_valid;
  logic [COUNT_WIDTH-1:0] out_codeword_total;
  logic [COUNT_WIDTH-1:0] out_error_total;

  int fail_count;
  int pending_count;
  int results_seen;
  int send_idle_pct = 17;
  int recv_idle_pct = 65;
  int words_sent    = 0;
  int streams_sent  = 0;
  int cfg_writes    = 0;
  int quiet_cycles  = 0;

  // settings as last written, used to build well-formed codewords
  logic [GEN_WIDTH-1:0] gen_now = GEN_RESET;
  logic [DWS_W-1:0]     dw_now  = DWS_RESET;
  logic [PAD_W-1:0]     pad_now = '0;

  crc_codeword_checker_unit uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_data_byte       (in_data_byte),
    .in_final_byte      (in_final_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_char_valid     (out_char_valid),
    .out_decoded_char   (out_decoded_char),
    .out_counts_valid   (out_counts_valid),
    .out_codeword_total (out_codeword_total),
    .out_error_total    (out_error_total)
  );

  crc_stream_checker chk (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_data_byte       (in_data_byte),
    .in_final_byte      (in_final_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_char_valid     (out_char_valid),
    .out_decoded_char   (out_decoded_char),
    .out_counts_valid   (out_counts_valid),
    .out_codeword_total (out_codeword_total),
    .out_error_total    (out_error_total),
    .fail_count         (fail_count),
    .pending_count      (pending_count),
    .results_seen       (results_seen)
  );

  always #5 clk = ~clk;

  always @(posedge clk) out_stall <= ($urandom_range(99) < recv_idle_pct);

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
        $display("tb_crc_codeword_checker_unit failed");
        $finish;
      end
    end
  end

  task automatic send_word(input logic [BYTE_W-1:0] data, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_data_byte  <= data;
    in_final_byte <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
  endtask

  // stop sending, let every expected result out, then cover words still in flight
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_GEN_POLY: gen_now = val[GEN_WIDTH-1:0];
      REG_DW_SIZE:  dw_now  = val[DWS_W-1:0];
      REG_PADDING:  pad_now = val[PAD_W-1:0];
      default: ;
    endcase
    cfg_writes++;
  endtask

  function automatic int unsigned encode_codeword(int unsigned data, int unsigned glen,
                                                  int unsigned deg);
    int unsigned r;
    r = data << deg;
    if (glen == 0) return data;
    for (int i = 20; i > deg; i--)
      if (((r >> (i - 1)) & 1) != 0) r ^= 32'(gen_now) << (i - 1 - deg);
    return (data << deg) | r;
  endfunction

  // padding, a run of codewords (a few corrupted), maybe a partial tail
  task automatic run_stream(input bit closed);
    bit                bits[$];
    int unsigned       glen, deg, dwl, cwl, ncw, cw;
    logic [BYTE_W-1:0] b8;
    glen = $clog2(int'(gen_now) + 1);
    deg  = (glen != 0) ? glen - 1 : 0;
    dwl  = (dw_now == DWS_WIDE) ? 8 : 4;
    cwl  = dwl + deg;
    for (int i = 0; i < pad_now; i++) bits.push_back(1'($urandom_range(1)));
    ncw = ($urandom_range(9) == 0) ? $urandom_range(24, 9) : $urandom_range(8, 1);
    repeat (ncw) begin
      cw = encode_codeword($urandom_range((1 << dwl) - 1), glen, deg);
      if ($urandom_range(7) == 0) cw ^= 32'd1 << $urandom_range(cwl - 1);
      for (int k = cwl - 1; k >= 0; k--) bits.push_back(1'((cw >> k) & 1));
    end
    if ($urandom_range(3) == 0)
      repeat ($urandom_range(cwl - 1, 1)) bits.push_back(1'($urandom_range(1)));
    while (bits.size() % 8 != 0) bits.push_back(1'($urandom_range(1)));
    for (int n = 0; n < bits.size(); n += 8) begin
      for (int k = 0; k < 8; k++) b8[7-k] = bits[n+k];
      send_word(b8, closed && (n + 8 == bits.size()));
    end
    streams_sent++;
  endtask

  task automatic shuffle_config();
    logic [CFG_W-1:0] g;
    logic [DWS_W-1:0] dw;
    settle();
    if ($urandom_range(2) != 0) begin
      case ($urandom_range(9))
        0:       g = 12'h001;
        1:       g = 12'hFFF;
        2:       g = '0;
        3:       g = 12'h800;
        default: g = CFG_W'($urandom_range(4095, 1));
      endcase
      write_reg(REG_GEN_POLY, g);
    end
    if ($urandom_range(2) != 0) begin
      if ($urandom_range(3) == 0) dw = DWS_W'($urandom_range(15));
      else dw = $urandom_range(1) ? DWS_WIDE : DWS_RESET;
      write_reg(REG_DW_SIZE, CFG_W'(dw));
    end
    if ($urandom_range(2) != 0) write_reg(REG_PADDING, CFG_W'($urandom_range(7)));
  endtask

  initial begin
    int target;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: 7-bit codewords, 4-bit data
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(8'hA5, 1'b1);
    settle();
    // widest codeword, most padding
    write_reg(REG_GEN_POLY, 12'hFFF);
    write_reg(REG_DW_SIZE, CFG_W'(DWS_WIDE));
    write_reg(REG_PADDING, 12'd7);
    send_word(8'h00, 1'b1);
    send_word(8'hFF, 1'b0);
    send_word(8'h80, 1'b0);
    send_word(8'h01, 1'b0);
    send_word(8'h7E, 1'b1);
    settle();
    // zero generator: every nonzero codeword counts as an error
    write_reg(REG_GEN_POLY, 12'h000);
    write_reg(REG_DW_SIZE, CFG_W'(DWS_RESET));
    write_reg(REG_PADDING, 12'd0);
    send_word(8'h0F, 1'b0);
    send_word(8'h30, 1'b1);
    settle();
    // leave a half byte pending, then switch to 8-bit data
    write_reg(REG_GEN_POLY, 12'h003);
    send_word(8'hFF, 1'b0);
    settle();
    write_reg(REG_DW_SIZE, CFG_W'(DWS_WIDE));
    send_word(8'h55, 1'b0);
    send_word(8'hAA, 1'b1);
    settle();
    // codeword length shrinks with bits already collected
    write_reg(REG_GEN_POLY, 12'hFFF);
    send_word(8'hAB, 1'b0);
    settle();
    write_reg(REG_GEN_POLY, 12'h001);
    write_reg(REG_DW_SIZE, 12'd15);
    send_word(8'hCD, 1'b1);
    settle();
    // padding write mid-stream reloads the skip count
    send_word(8'h3C, 1'b0);
    settle();
    write_reg(REG_PADDING, 12'd3);
    write_reg(REG_DW_SIZE, 12'd0);
    send_word(8'hE7, 1'b0);
    send_word(8'h81, 1'b1);

    for (int mode = 0; mode < 3; mode++) begin
      settle();
      case (mode)
        0: begin send_idle_pct = 17; recv_idle_pct = 65; end
        1: begin send_idle_pct = 65; recv_idle_pct = 17; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      target = words_sent + WORDS_PER_MODE;
      while (words_sent < target) begin
        if ($urandom_range(2) == 0) shuffle_config();
        // now and then a stream is left open and runs into the next one
        run_stream($urandom_range(9) != 0);
      end
    end

    settle();
    @(posedge clk);
    $display("sent %0d words in %0d streams over %0d register writes, checked %0d results",
             words_sent, streams_sent, cfg_writes, results_seen);
    if (fail_count == 0 && pending_count == 0) begin
      $display("tb_crc_codeword_checker_unit passed");
    end else begin
      $display("tb_crc_codeword_checker_unit failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/crc_chk_pkg.sv
hdl/crc_chk_ctrl.sv
hdl/crc_chk_dpath.sv
hdl/crc_codeword_checker_unit.sv
hdl/crc_chk_checker.sv
verif/crc_stream_checker.sv
verif/tb_crc_codeword_checker_unit.sv
